// ----- hdl/bsa_pkg.sv -----
// Shared types, codes and field widths of the bitmap slot allocator.
package bsa_pkg;

  // Default geometry of the occupancy bitmap
  localparam int WORDS_DEF         = 64;
  localparam int BITS_PER_WORD_DEF = 32;

  // Field and register widths
  localparam int OFFSET_W = 23;
  localparam int ELEM_W   = 13;
  localparam int NWORDS_W = 7;
  localparam int SLOT_O_W = 11;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 40;

  localparam logic [ELEM_W-1:0]   MAX_ELEM      = ELEM_W'(4096);
  localparam logic [ELEM_W-1:0]   ELEM_RST      = ELEM_W'(1);
  localparam logic [NWORDS_W-1:0] NWORDS_RST    = NWORDS_W'(64);

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNALLOC = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_ELEM_SIZE    = 1'b0,
    CFG_WORDS_IN_USE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_SLOT,
    S_ALLOC_MUL,
    S_FREE_DIV_IDX,
    S_FREE_READ,
    S_FREE_CHK,
    S_RESP
  } state_t;

endpackage

// ----- hdl/bsa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bsa_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module bsa_div
  import bsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OFFSET_W-1:0] dividend,
  input  logic [ELEM_W-1:0]   divisor,
  output logic                done,
  output logic [OFFSET_W-1:0] quotient
);

  localparam int CNT_W = $clog2(OFFSET_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OFFSET_W-1:0] q_r, q_nxt;
  logic [ELEM_W-1:0]   rem_r, rem_nxt;
  logic [ELEM_W-1:0]   div_r, div_nxt;
  logic [ELEM_W:0]     trial;
  logic [ELEM_W:0]     diff;

  always_comb begin
    trial    = {rem_r, q_r[OFFSET_W-1]};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // shift the next dividend bit in, subtract when the divisor fits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[ELEM_W-1:0];
        q_nxt   = {q_r[OFFSET_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ELEM_W-1:0];
        q_nxt   = {q_r[OFFSET_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(OFFSET_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hdl/bitmap_slot_allocator.sv -----
// First-fit slot allocator for a pool of fixed-size elements. Occupancy lives
// in a WORDS x BITS_PER_WORD bitmap RAM (BITS_PER_WORD a power of two); after
// reset a clearing pass writes zero to every word, one word a cycle, and no
// item is taken until it ends. An allocate reads the words in use from word 0
// up, one word a cycle through the RAM read port, and takes the lowest clear
// bit of the first word that is not full; a full pool answers once every word
// in use has been read. A free runs the serial divider once (offset by element
// size, one quotient bit a cycle), splits the slot index into word and bit by
// shift and mask, then reads one word and writes it back with the bit cleared
// when that bit was set; a slot out of range gets no write. One item is worked
// at a time; the next item is taken while the last result still waits in the
// output register.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int WORDS         = WORDS_DEF,
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // [22:0] free_offset, [23] zero
  input  logic                in_tuser,   // [0] cmd
  // result items
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // [1:0] status, [24:2] alloc_offset,
                                          // [35:25] slot_index, [39:36] zero
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [ELEM_W-1:0]   cfg_data
);

  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(WORDS + 1);
  localparam int BW     = $clog2(BITS_PER_WORD);
  localparam int SLOT_W = $clog2(WORDS * BITS_PER_WORD);
  localparam int PROD_W = ELEM_W + SLOT_W;

  function automatic logic [BW-1:0] first_zero(input logic [BITS_PER_WORD-1:0] w);
    logic [BW-1:0] pos;
    pos = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BW'(i);
      end
    end
    return pos;
  endfunction

  state_t state_r, state_nxt;

  logic [ELEM_W-1:0]        elem_size_r;
  logic [NWORDS_W-1:0]      words_in_use_r;
  logic [ELEM_W-1:0]        es_eff;
  logic [CNT_W-1:0]         nw;

  logic [AW-1:0]            clr_idx_r;
  logic [CNT_W-1:0]         issue_idx_r;
  logic                     rd_vld_r;
  logic [AW-1:0]            rd_word_r;
  logic [AW-1:0]            word_r;
  logic [BW-1:0]            bit_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [OFFSET_W-1:0]      idx_r;
  logic [OFFSET_W-1:0]      free_word;

  logic [STATUS_W-1:0]      res_status_r;
  logic [OFFSET_W-1:0]      res_aoff_r;
  logic [SLOT_O_W-1:0]      res_slot_r;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic                     in_acc;
  logic                     clr_last;
  logic                     issue;
  logic                     found;
  logic                     pool_full;
  logic                     in_range;
  logic                     bit_set;
  logic                     resp_load;
  logic [PROD_W-1:0]        prod;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [BITS_PER_WORD-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [BITS_PER_WORD-1:0] ram_rdata;
  logic [BITS_PER_WORD-1:0] bit_mask;

  logic                     div_start;
  logic [OFFSET_W-1:0]      div_dividend;
  logic [ELEM_W-1:0]        div_divisor;
  logic                     div_done;
  logic [OFFSET_W-1:0]      div_quot;

  bsa_ram #(
    .WIDTH (BITS_PER_WORD),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bsa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot)
  );

  // effective configuration
  always_comb begin
    if (elem_size_r == '0) begin
      es_eff = ELEM_W'(1);
    end else if (elem_size_r > MAX_ELEM) begin
      es_eff = MAX_ELEM;
    end else begin
      es_eff = elem_size_r;
    end
    if (32'(words_in_use_r) > 32'(WORDS)) begin
      nw = CNT_W'(WORDS);
    end else begin
      nw = CNT_W'(words_in_use_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign clr_last  = (clr_idx_r == AW'(WORDS - 1));

  assign issue     = (state_r == S_ALLOC_SCAN) && (32'(issue_idx_r) < 32'(nw));
  assign found     = (state_r == S_ALLOC_SCAN) && rd_vld_r && !(&ram_rdata);
  assign pool_full = (state_r == S_ALLOC_SCAN) && !rd_vld_r && !issue;
  // split the slot index into word and bit
  assign free_word = idx_r >> BW;
  assign in_range  = 32'(free_word) < 32'(nw);
  assign bit_mask  = BITS_PER_WORD'(1) << bit_r;
  assign bit_set   = |(ram_rdata & bit_mask);
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_tready);
  assign prod      = es_eff * slot_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_FREE) ? S_FREE_DIV_IDX : S_ALLOC_SCAN;
        end
      end
      S_ALLOC_SCAN: begin
        if (found) begin
          state_nxt = S_ALLOC_SLOT;
        end else if (pool_full) begin
          state_nxt = S_RESP;
        end
      end
      S_ALLOC_SLOT: state_nxt = S_ALLOC_MUL;
      S_ALLOC_MUL:  state_nxt = S_RESP;
      S_FREE_DIV_IDX: begin
        if (div_done) state_nxt = S_FREE_READ;
      end
      S_FREE_READ: begin
        state_nxt = in_range ? S_FREE_CHK : S_RESP;
      end
      S_FREE_CHK: state_nxt = S_RESP;
      S_RESP: begin
        if (resp_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // memory and divider controls
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = clr_idx_r;
    ram_wdata    = '0;
    ram_raddr    = issue_idx_r[AW-1:0];
    div_start    = 1'b0;
    div_dividend = in_tdata[OFFSET_W-1:0];
    div_divisor  = es_eff;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        div_start = in_acc && (in_tuser == CMD_FREE);
      end
      S_ALLOC_SCAN: begin
        ram_we    = found;
        ram_waddr = rd_word_r;
        ram_wdata = ram_rdata | (BITS_PER_WORD'(1) << first_zero(ram_rdata));
      end
      S_FREE_READ: begin
        ram_raddr = free_word[AW-1:0];
      end
      S_FREE_CHK: begin
        ram_we    = bit_set;
        ram_waddr = word_r;
        ram_wdata = ram_rdata & ~bit_mask;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_idx_r      <= '0;
      elem_size_r    <= ELEM_RST;
      words_in_use_r <= NWORDS_RST;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ELEM_SIZE:    elem_size_r    <= cfg_data;
          CFG_WORDS_IN_USE: words_in_use_r <= cfg_data[NWORDS_W-1:0];
          default:          elem_size_r    <= elem_size_r;
        endcase
      end
      // a read lands next cycle; drop it once the scan has stopped
      rd_vld_r <= issue && !found;
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      issue_idx_r <= '0;
    end else if (issue) begin
      issue_idx_r <= issue_idx_r + CNT_W'(1);
    end
    rd_word_r <= issue_idx_r[AW-1:0];

    case (state_r)
      S_ALLOC_SCAN: begin
        word_r       <= rd_word_r;
        bit_r        <= first_zero(ram_rdata);
        res_status_r <= ST_FULL;
        res_aoff_r   <= '0;
        res_slot_r   <= '0;
      end
      S_ALLOC_SLOT: begin
        slot_r <= SLOT_W'(32'(word_r) * BITS_PER_WORD) + SLOT_W'(bit_r);
      end
      S_ALLOC_MUL: begin
        res_status_r <= ST_OK;
        res_aoff_r   <= OFFSET_W'(prod);
        res_slot_r   <= SLOT_O_W'(slot_r);
      end
      S_FREE_DIV_IDX: begin
        idx_r <= div_quot;
      end
      S_FREE_READ: begin
        word_r       <= free_word[AW-1:0];
        bit_r        <= idx_r[BW-1:0];
        res_status_r <= ST_RANGE;
        res_aoff_r   <= '0;
        res_slot_r   <= '0;
      end
      S_FREE_CHK: begin
        res_status_r <= bit_set ? ST_OK : ST_UNALLOC;
        res_slot_r   <= SLOT_O_W'(idx_r);
      end
      default: begin
        slot_r <= slot_r;
      end
    endcase

    if (resp_load) begin
      out_data_r <= {4'b0000, res_slot_r, res_aoff_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the bitmap slot allocator: streamed ops vs. a bit-exact predictor.
`timescale 1ns / 1ps

module tb_top;
  import bsa_pkg::*;

  localparam int BPW       = BITS_PER_WORD_DEF;
  localparam int CYCLE_CAP = 600000;

  typedef struct {
    cmd_t              cmd;
    logic [OFFSET_W-1:0] offset;
  } pool_req_t;

  typedef struct {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
    logic [SLOT_O_W-1:0] slot;
  } pool_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic              in_tuser = CMD_ALLOC;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = '0;
  logic [ELEM_W-1:0] cfg_data = '0;

  bitmap_slot_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state: occupancy and register shadows
  logic [BPW-1:0]      occupancy [WORDS_DEF];
  logic [ELEM_W-1:0]   elem_size_q = ELEM_RST;
  logic [NWORDS_W-1:0] words_in_use_q = NWORDS_RST;

  pool_req_t    op_q[$];
  pool_result_t result_q[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int unsigned eff_elem_size();
    if (elem_size_q == '0) return 1;
    if (elem_size_q > MAX_ELEM) return MAX_ELEM;
    return elem_size_q;
  endfunction

  function automatic int unsigned eff_words();
    return (words_in_use_q > WORDS_DEF) ? WORDS_DEF : words_in_use_q;
  endfunction

  // Apply one op to the shadow bitmap and return the result the block owes
  function automatic pool_result_t apply_pool_op(pool_req_t req);
    pool_result_t r;
    int unsigned  es, nw, idx, w, b;
    bit           found;
    r = '{status: ST_OK, offset: '0, slot: '0};
    es = eff_elem_size();
    nw = eff_words();
    found = 1'b0;
    if (req.cmd == CMD_ALLOC) begin
      for (w = 0; w < nw && !found; w++) begin
        if (occupancy[w] != '1) begin
          b = 0;
          while (occupancy[w][b]) b++;
          occupancy[w][b] = 1'b1;
          idx = w * BPW + b;
          r.slot = SLOT_O_W'(idx);
          r.offset = OFFSET_W'(es * idx);
          found = 1'b1;
        end
      end
      if (!found) r.status = ST_FULL;
    end else begin
      idx = req.offset / es;
      w = idx / BPW;
      b = idx % BPW;
      if (w >= nw) begin
        r.status = ST_RANGE;
      end else if (!occupancy[w][b]) begin
        r.status = ST_UNALLOC;
        r.slot = SLOT_O_W'(idx);
      end else begin
        occupancy[w][b] = 1'b0;
        r.slot = SLOT_O_W'(idx);
      end
    end
    return r;
  endfunction

  // Input side: present the oldest pending op, predict it when taken
  always @(posedge clk) begin : drive_ops
    pool_req_t cur;
    int        gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      gap = tx_gap;
      if (in_tvalid && in_tready) begin
        cur = op_q.pop_front();
        result_q.push_back(apply_pool_op(cur));
        gap = tx_idle ? $urandom_range(0, 10) : 0;
      end else if (!in_tvalid && gap > 0) begin
        gap--;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered item
      end else if (gap == 0 && op_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, op_q[0].offset};
        in_tuser <= op_q[0].cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
      tx_gap <= gap;
    end
  end

  // Long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: check each taken item against the oldest prediction
  always @(posedge clk) begin : check_results
    pool_result_t exp_r;
    status_t      got_status;
    int           stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      stall = (rx_stall > 0) ? rx_stall - 1 : 0;
      if (out_tvalid && out_tready) begin
        got_status = status_t'(out_tdata[1:0]);
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          exp_r = result_q.pop_front();
          if (got_status != exp_r.status) begin
            $display("%0t: status expected %s got %s", $time, exp_r.status.name(),
                     got_status.name());
            mismatches++;
          end
          if (out_tdata[24:2] != exp_r.offset) begin
            $display("%0t: alloc_offset expected %0d got %0d", $time, exp_r.offset,
                     out_tdata[24:2]);
            mismatches++;
          end
          if (out_tdata[35:25] != exp_r.slot) begin
            $display("%0t: slot_index expected %0d got %0d", $time, exp_r.slot,
                     out_tdata[35:25]);
            mismatches++;
          end
        end
        stall = rx_idle ? $urandom_range(0, 10) : 0;
      end
      rx_stall <= stall;
      out_tready <= (stall == 0) && (hold_left == 0);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [ELEM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ELEM_SIZE) elem_size_q = val;
    else words_in_use_q = val[NWORDS_W-1:0];
  endtask

  task automatic push_op(cmd_t cmd, int unsigned offset);
    pool_req_t req;
    req.cmd = cmd;
    req.offset = OFFSET_W'(offset);
    op_q.push_back(req);
  endtask

  task automatic wait_drained();
    while (op_q.size() != 0 || result_q.size() != 0) @(posedge clk);
  endtask

  // Mostly allocs and frees aimed at live slots; the rest is noise
  task automatic queue_random_ops(int count, int alloc_pct);
    int unsigned es, nw, live, hi, slot, roll;
    es = eff_elem_size();
    nw = (eff_words() == 0) ? 1 : eff_words();
    live = 0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        push_op(CMD_ALLOC, $urandom);
        live++;
      end else if (roll < 92) begin
        hi = (live + 2 < nw * BPW) ? live + 2 : nw * BPW - 1;
        slot = (roll < 85) ? $urandom_range(0, hi) : $urandom_range(0, nw * BPW - 1);
        push_op(CMD_FREE, slot * es + $urandom_range(0, es - 1));
        if (live > 0) live--;
      end else begin
        push_op(CMD_FREE, $urandom & 32'h7FFFFF);
      end
    end
  endtask

  task automatic random_phase(int unsigned es, int unsigned nw, int alloc_pct, int count,
                              int phase_no);
    write_reg(CFG_ELEM_SIZE, ELEM_W'(es));
    write_reg(CFG_WORDS_IN_USE, ELEM_W'(nw));
    tx_idle <= (phase_no % 3) != 0;
    rx_idle <= (phase_no % 4) != 1;
    queue_random_ops(count, alloc_pct);
    wait_drained();
  endtask

  initial begin
    for (int w = 0; w < WORDS_DEF; w++) occupancy[w] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unit elements, all 64 words
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
    push_op(CMD_ALLOC, 0);
    push_op(CMD_ALLOC, 23'h7FFFFF);
    push_op(CMD_FREE, 0);
    push_op(CMD_FREE, 0);
    push_op(CMD_FREE, 1);
    push_op(CMD_FREE, 2047);
    push_op(CMD_FREE, 2048);
    push_op(CMD_FREE, 23'h7FFFFF);
    push_op(CMD_ALLOC, 0);
    wait_drained();

    // Zero element size acts as one
    write_reg(CFG_ELEM_SIZE, '0);
    push_op(CMD_ALLOC, 0);
    push_op(CMD_FREE, 1);
    wait_drained();

    // Oversized element and word count saturate
    write_reg(CFG_ELEM_SIZE, '1);
    write_reg(CFG_WORDS_IN_USE, '1);
    push_op(CMD_ALLOC, 0);
    push_op(CMD_FREE, 4096 + 100);
    push_op(CMD_FREE, 23'h7FFFFF);
    push_op(CMD_ALLOC, 0);
    wait_drained();

    // Empty pool: allocate is full, free is out of range
    write_reg(CFG_WORDS_IN_USE, '0);
    push_op(CMD_ALLOC, 0);
    push_op(CMD_FREE, 0);
    wait_drained();

    write_reg(CFG_ELEM_SIZE, ELEM_W'(4096));
    write_reg(CFG_WORDS_IN_USE, ELEM_W'(1));
    push_op(CMD_FREE, 4096 * BPW);
    push_op(CMD_ALLOC, 0);
    wait_drained();

    random_phase(1, 3, 65, 110, 1);
    // shrink, then grow back over the kept words
    random_phase(1, 1, 50, 80, 2);
    random_phase(1, 3, 30, 80, 3);

    // Stall the output while the input keeps offering
    write_reg(CFG_ELEM_SIZE, ELEM_W'(4096));
    write_reg(CFG_WORDS_IN_USE, ELEM_W'(64));
    tx_idle <= 1'b0;
    rx_idle <= 1'b1;
    hold_reqs <= hold_reqs + 1;
    queue_random_ops(120, 70);
    wait_drained();

    random_phase($urandom_range(1, 4096), $urandom_range(1, 4), 55, 100, 5);
    random_phase(13'h1FFF, 2, 60, 80, 6);
    random_phase(7, 64, 80, 150, 7);
    random_phase($urandom_range(0, 8191), $urandom_range(0, 127), 50, 120, 8);
    random_phase(1, 0, 50, 30, 9);

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
